>>> design/asfa_pkg.sv
// ----------------------------------------------------------------------------
// asfa_pkg: shared types and constants for the ADC scan frame assembler
// Sample and period formats, slot count, register indexes, result beat type.
// ----------------------------------------------------------------------------
`default_nettype none

package asfa_pkg;

  localparam int SampleBits     = 12;
  localparam int PeriodFracBits = 16;
  localparam int SlotCount      = 6;
  localparam int SlotIdxBits    = $clog2(SlotCount);
  localparam int ChanBits       = 4;
  localparam int StampBits      = 64;
  localparam int PeriodBits     = 40;
  localparam int CountBits      = 32;
  localparam int CfgIdxBits     = 4;
  localparam int CfgDataBits    = 64;

  localparam logic [SlotCount-1:0] FullMask = {SlotCount{1'b1}};

  localparam logic [CfgIdxBits-1:0] RegStartTime = CfgIdxBits'(6);
  localparam logic [CfgIdxBits-1:0] RegPeriod    = CfgIdxBits'(7);

  localparam logic [PeriodBits-1:0] PeriodReset = PeriodBits'(65536000);

  typedef logic [SampleBits-1:0] sample_t;

  typedef struct packed {
    logic                 frame_done;
    sample_t [SlotCount-1:0] samples;
    logic [StampBits-1:0] timestamp;
    logic [CountBits-1:0] invalid_cnt;
    logic [CountBits-1:0] incomplete_cnt;
    logic [CountBits-1:0] frame_cnt;
  } res_t;

endpackage

`default_nettype wire

>>> design/adc_scan_frame_assembler_top.sv
// ----------------------------------------------------------------------------
// adc_scan_frame_assembler_top: three-phase V/I frame assembler
// Matches tagged conversions to six slots and emits stamped frames.
// ----------------------------------------------------------------------------
// Each accepted input beat gives one result beat, registered in the result
// register or the skid. Throughput: one input beat per cycle unless in_stall_o;
// slot match, mask update and stamp add are combinational up to that register.
// A two-entry output buffer (result register plus skid) keeps input open
// while one result is stalled. Reset clears mask, offset, counters and
// restores the slot map to 0..5 and a period of 1000 us.
`default_nettype none

module adc_scan_frame_assembler_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [asfa_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  wire logic [asfa_pkg::CfgDataBits-1:0]    cfg_data_i,
  // input beats
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                sample_valid_i,
  input  wire logic                                adc_unit_i,
  input  wire logic [asfa_pkg::ChanBits-1:0]       channel_i,
  input  wire logic [asfa_pkg::SampleBits-1:0]     raw_sample_i,
  // result beats
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     frame_done_o,
  output logic [asfa_pkg::SampleBits-1:0]          voltage_1_o,
  output logic [asfa_pkg::SampleBits-1:0]          current_1_o,
  output logic [asfa_pkg::SampleBits-1:0]          voltage_2_o,
  output logic [asfa_pkg::SampleBits-1:0]          current_2_o,
  output logic [asfa_pkg::SampleBits-1:0]          voltage_3_o,
  output logic [asfa_pkg::SampleBits-1:0]          current_3_o,
  output logic [asfa_pkg::StampBits-1:0]           frame_stamp_o,
  output logic [asfa_pkg::CountBits-1:0]           invalid_count_o,
  output logic [asfa_pkg::CountBits-1:0]           incomplete_count_o,
  output logic [asfa_pkg::CountBits-1:0]           frame_count_o
);

  localparam int SlotCount = asfa_pkg::SlotCount;

  // configuration registers
  logic [asfa_pkg::ChanBits-1:0]   slot_chan_q [SlotCount];
  logic [asfa_pkg::StampBits-1:0]  start_time_q;
  logic [asfa_pkg::PeriodBits-1:0] period_q;

  // assembly state
  logic [SlotCount-1:0]            mask_q, mask_d;
  asfa_pkg::sample_t               samples_q [SlotCount];
  logic [asfa_pkg::StampBits-1:0]  offset_q, offset_d;
  logic [asfa_pkg::CountBits-1:0]  invalid_cnt_q, invalid_cnt_d;
  logic [asfa_pkg::CountBits-1:0]  incomplete_cnt_q, incomplete_cnt_d;
  logic [asfa_pkg::CountBits-1:0]  frame_cnt_q, frame_cnt_d;

  // output buffer
  asfa_pkg::res_t out_q, skid_q, res_d;
  logic           out_valid_q, skid_valid_q;

  logic                             in_acc, out_take, cfg_acc;
  logic                             conv_ok, hit, full;
  logic [asfa_pkg::SlotIdxBits-1:0] hit_idx;
  logic [SlotCount-1:0]             hit_bit, mask_base;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;

  // lowest matching slot wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int s = SlotCount - 1; s >= 0; s--) begin
      if (slot_chan_q[s] == channel_i) begin
        hit     = 1'b1;
        hit_idx = asfa_pkg::SlotIdxBits'(s);
      end
    end
  end

  assign conv_ok   = sample_valid_i && !adc_unit_i;
  assign hit_bit   = SlotCount'(1) << hit_idx;
  assign mask_base = ((mask_q & hit_bit) != '0) ? '0 : mask_q;
  assign full      = conv_ok && hit && ((mask_base | hit_bit) == asfa_pkg::FullMask);

  always_comb begin
    mask_d           = mask_q;
    offset_d         = offset_q;
    invalid_cnt_d    = invalid_cnt_q;
    incomplete_cnt_d = incomplete_cnt_q;
    frame_cnt_d      = frame_cnt_q;
    res_d            = '0;
    if (!conv_ok || !hit) begin
      invalid_cnt_d = invalid_cnt_q + 1'b1;
    end else begin
      if ((mask_q & hit_bit) != '0) begin
        incomplete_cnt_d = incomplete_cnt_q + 1'b1;
      end
      mask_d = mask_base | hit_bit;
      if (full) begin
        mask_d      = '0;
        offset_d    = offset_q + asfa_pkg::StampBits'(period_q);
        frame_cnt_d = frame_cnt_q + 1'b1;
        res_d.frame_done = 1'b1;
        for (int k = 0; k < SlotCount; k++) begin
          res_d.samples[k] = (hit_idx == asfa_pkg::SlotIdxBits'(k)) ? raw_sample_i
                                                                     : samples_q[k];
        end
        res_d.timestamp = start_time_q + asfa_pkg::StampBits'(
                          offset_q[asfa_pkg::StampBits-1:asfa_pkg::PeriodFracBits]);
      end
    end
    res_d.invalid_cnt    = invalid_cnt_d;
    res_d.incomplete_cnt = incomplete_cnt_d;
    res_d.frame_cnt      = frame_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SlotCount; s++) begin
        slot_chan_q[s] <= asfa_pkg::ChanBits'(s);
      end
      start_time_q <= '0;
      period_q     <= asfa_pkg::PeriodReset;
    end else if (cfg_acc) begin
      if (cfg_index_i < asfa_pkg::CfgIdxBits'(SlotCount)) begin
        slot_chan_q[cfg_index_i[asfa_pkg::SlotIdxBits-1:0]] <=
          cfg_data_i[asfa_pkg::ChanBits-1:0];
      end else if (cfg_index_i == asfa_pkg::RegStartTime) begin
        start_time_q <= cfg_data_i;
      end else if (cfg_index_i == asfa_pkg::RegPeriod) begin
        period_q <= cfg_data_i[asfa_pkg::PeriodBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q           <= '0;
      offset_q         <= '0;
      invalid_cnt_q    <= '0;
      incomplete_cnt_q <= '0;
      frame_cnt_q      <= '0;
    end else if (in_acc) begin
      mask_q           <= mask_d;
      offset_q         <= offset_d;
      invalid_cnt_q    <= invalid_cnt_d;
      incomplete_cnt_q <= incomplete_cnt_d;
      frame_cnt_q      <= frame_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && conv_ok && hit) begin
      samples_q[hit_idx] <= raw_sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_take) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign frame_done_o       = out_q.frame_done;
  assign voltage_1_o        = out_q.samples[0];
  assign current_1_o        = out_q.samples[1];
  assign voltage_2_o        = out_q.samples[2];
  assign current_2_o        = out_q.samples[3];
  assign voltage_3_o        = out_q.samples[4];
  assign current_3_o        = out_q.samples[5];
  assign frame_stamp_o      = out_q.timestamp;
  assign invalid_count_o    = out_q.invalid_cnt;
  assign incomplete_count_o = out_q.incomplete_cnt;
  assign frame_count_o      = out_q.frame_cnt;

  // mask never rests full: a completed scan clears it in the same beat
  a_mask_never_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mask_q != asfa_pkg::FullMask)
    else $error("pending mask left full");

  // skid entry only holds a beat behind a stalled result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid valid without result valid");

  // rejected conversion leaves the mask and frame counter alone
  a_reject_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !conv_ok) |=> ($stable(mask_q) && $stable(frame_cnt_q)))
    else $error("rejected conversion changed assembly state");

  // frame counter steps exactly on completed scans
  a_frame_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (frame_cnt_q == $past(frame_cnt_q) + asfa_pkg::CountBits'($past(full))))
    else $error("frame counter out of step");

  // the offset advances only with a completed frame
  a_offset_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && full) |=> $stable(offset_q))
    else $error("time offset moved without a frame");

endmodule

`default_nettype wire

>>> dv/asfa_frame_checker.sv
// ----------------------------------------------------------------------------
// asfa_frame_checker: scoreboard for the ADC scan frame assembler
// Watches the config, input and result channels. Keeps its own slot map,
// pending mask, time offset and counters, predicts one result beat per
// accepted input beat and compares every result beat field by field.
// ----------------------------------------------------------------------------
module asfa_frame_checker
  import asfa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  sample_valid_i,
  input  logic                  adc_unit_i,
  input  logic [ChanBits-1:0]   channel_i,
  input  sample_t               raw_sample_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  frame_done_i,
  input  sample_t               voltage_1_i,
  input  sample_t               current_1_i,
  input  sample_t               voltage_2_i,
  input  sample_t               current_2_i,
  input  sample_t               voltage_3_i,
  input  sample_t               current_3_i,
  input  logic [StampBits-1:0]  frame_stamp_i,
  input  logic [CountBits-1:0]  invalid_count_i,
  input  logic [CountBits-1:0]  incomplete_count_i,
  input  logic [CountBits-1:0]  frame_count_i,
  output int                    fail_count_o,
  output int                    pending_beats_o
);

  logic [ChanBits-1:0]            slot_chan [SlotCount];
  logic [StampBits-1:0]           start_us;
  logic [PeriodBits-1:0]          period;
  logic [SlotCount-1:0]           pend_mask;
  sample_t [SlotCount-1:0]        pend_samples;
  logic [StampBits-1:0]           offset;
  logic [CountBits-1:0]           invalid_cnt;
  logic [CountBits-1:0]           incomplete_cnt;
  logic [CountBits-1:0]           frame_cnt;
  res_t                           frame_beats_q [$];
  res_t                           predicted;
  res_t                           want;

  task automatic flag_mismatch(input string msg);
    $display("checker: %s", msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] exp_val);
    if (got !== exp_val) begin
      flag_mismatch($sformatf("%s got %0h want %0h (frame %0d)", name, got, exp_val,
                              frame_cnt));
    end
  endtask

  task automatic assemble_beat(input logic smp_valid, input logic unit,
                               input logic [ChanBits-1:0] ch, input sample_t raw,
                               output res_t r);
    int hit;
    int s;
    logic [SlotCount-1:0] slot_bit;
    r = '0;
    hit = -1;
    for (s = SlotCount - 1; s >= 0; s--) begin
      if (slot_chan[s] == ch) hit = s;
    end
    if (!smp_valid || unit || hit < 0) begin
      invalid_cnt++;
    end else begin
      slot_bit = SlotCount'(1) << hit;
      if ((pend_mask & slot_bit) != '0) begin
        incomplete_cnt++;
        pend_mask = '0;
      end
      pend_samples[hit] = raw;
      pend_mask |= slot_bit;
      if (pend_mask == FullMask) begin
        r.frame_done = 1'b1;
        r.samples    = pend_samples;
        r.timestamp  = start_us + (offset >> PeriodFracBits);
        offset       = offset + StampBits'(period);
        frame_cnt++;
        pend_mask = '0;
      end
    end
    r.invalid_cnt    = invalid_cnt;
    r.incomplete_cnt = incomplete_cnt;
    r.frame_cnt      = frame_cnt;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SlotCount; s++) slot_chan[s] = ChanBits'(s);
      start_us       = '0;
      period         = PeriodReset;
      pend_mask      = '0;
      pend_samples   = '0;
      offset         = '0;
      invalid_cnt    = '0;
      incomplete_cnt = '0;
      frame_cnt      = '0;
      frame_beats_q.delete();
      pending_beats_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (frame_beats_q.size() == 0) begin
          flag_mismatch("result beat with nothing expected");
        end else begin
          want = frame_beats_q.pop_front();
          check_field("frame_done", frame_done_i, want.frame_done);
          check_field("voltage_1", voltage_1_i, want.samples[0]);
          check_field("current_1", current_1_i, want.samples[1]);
          check_field("voltage_2", voltage_2_i, want.samples[2]);
          check_field("current_2", current_2_i, want.samples[3]);
          check_field("voltage_3", voltage_3_i, want.samples[4]);
          check_field("current_3", current_3_i, want.samples[5]);
          check_field("frame_stamp", frame_stamp_i, want.timestamp);
          check_field("invalid_count", invalid_count_i, want.invalid_cnt);
          check_field("incomplete_count", incomplete_count_i, want.incomplete_cnt);
          check_field("frame_count", frame_count_i, want.frame_cnt);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i < CfgIdxBits'(SlotCount)) begin
          slot_chan[cfg_index_i[SlotIdxBits-1:0]] = cfg_data_i[ChanBits-1:0];
        end else if (cfg_index_i == RegStartTime) begin
          start_us = cfg_data_i;
        end else if (cfg_index_i == RegPeriod) begin
          period = cfg_data_i[PeriodBits-1:0];
        end
      end
      if (in_valid_i && !in_stall_i) begin
        assemble_beat(sample_valid_i, adc_unit_i, channel_i, raw_sample_i, predicted);
        frame_beats_q.push_back(predicted);
      end
      pending_beats_o = frame_beats_q.size();
    end
  end

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for adc_scan_frame_assembler_top
// Directed beats for rejects, unmatched channels, slot repeats and frames,
// then random scans with noise and broken scans over several slot maps,
// start times and periods, under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import asfa_pkg::*;

  localparam int StallLimit = 1000;
  localparam int SegItems   = 153;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid;
  logic [CfgIdxBits-1:0]  cfg_index;
  logic [CfgDataBits-1:0] cfg_data;
  logic                   in_valid;
  logic                   sample_valid;
  logic                   adc_unit;
  logic [ChanBits-1:0]    channel;
  sample_t                raw_sample;
  logic                   out_stall;

  logic                   cfg_ready_o;
  logic                   in_stall_o;
  logic                   out_valid_o;
  logic                   frame_done_o;
  sample_t                voltage_1_o, current_1_o, voltage_2_o;
  sample_t                current_2_o, voltage_3_o, current_3_o;
  logic [StampBits-1:0]   frame_stamp_o;
  logic [CountBits-1:0]   invalid_count_o;
  logic [CountBits-1:0]   incomplete_count_o;
  logic [CountBits-1:0]   frame_count_o;

  int                     fail_count;
  int                     pending_beats;
  int                     send_idle_pct;
  int                     recv_idle_pct;
  int                     items_sent;
  int                     idle_cycles;
  logic [ChanBits-1:0]    scan_chan [SlotCount];

  adc_scan_frame_assembler_top u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .sample_valid_i     (sample_valid),
    .adc_unit_i         (adc_unit),
    .channel_i          (channel),
    .raw_sample_i       (raw_sample),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .frame_done_o       (frame_done_o),
    .voltage_1_o        (voltage_1_o),
    .current_1_o        (current_1_o),
    .voltage_2_o        (voltage_2_o),
    .current_2_o        (current_2_o),
    .voltage_3_o        (voltage_3_o),
    .current_3_o        (current_3_o),
    .frame_stamp_o      (frame_stamp_o),
    .invalid_count_o    (invalid_count_o),
    .incomplete_count_o (incomplete_count_o),
    .frame_count_o      (frame_count_o)
  );

  asfa_frame_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall_o),
    .sample_valid_i     (sample_valid),
    .adc_unit_i         (adc_unit),
    .channel_i          (channel),
    .raw_sample_i       (raw_sample),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall),
    .frame_done_i       (frame_done_o),
    .voltage_1_i        (voltage_1_o),
    .current_1_i        (current_1_o),
    .voltage_2_i        (voltage_2_o),
    .current_2_i        (current_2_o),
    .voltage_3_i        (voltage_3_o),
    .current_3_i        (current_3_o),
    .frame_stamp_i      (frame_stamp_o),
    .invalid_count_i    (invalid_count_o),
    .incomplete_count_i (incomplete_count_o),
    .frame_count_i      (frame_count_o),
    .fail_count_o       (fail_count),
    .pending_beats_o    (pending_beats)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // entered and left at a falling edge; valid stays high after the beat
  task automatic send_item(input logic smp_valid, input logic unit,
                           input logic [ChanBits-1:0] ch, input sample_t raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid     <= 1'b1;
    sample_valid <= smp_valid;
    adc_unit     <= unit;
    channel      <= ch;
    raw_sample   <= raw;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx,
                           input logic [CfgDataBits-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    if (idx < CfgIdxBits'(SlotCount)) scan_chan[idx[SlotIdxBits-1:0]] = data[ChanBits-1:0];
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_beats != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // kind 0: distinct map, random timing; 1: distinct map, extreme timing;
  // 2: map with duplicate channels, raw 64-bit data
  task automatic configure(input int kind, input int phase);
    logic [ChanBits-1:0]    pool [16];
    logic [ChanBits-1:0]    tmp;
    logic [CfgDataBits-1:0] data;
    logic [CfgDataBits-1:0] start_val;
    logic [CfgDataBits-1:0] period_val;
    int j;
    int k;
    wait_drained();
    for (j = 0; j < 16; j++) pool[j] = ChanBits'(j);
    for (j = 15; j > 0; j--) begin
      k = $urandom_range(j);
      tmp = pool[j];
      pool[j] = pool[k];
      pool[k] = tmp;
    end
    if (kind == 2) begin
      j = $urandom_range(SlotCount - 1, 1);
      pool[j] = pool[$urandom_range(j - 1)];
    end
    start_val  = {$urandom, $urandom};
    period_val = {$urandom, $urandom};
    if (kind == 0) begin
      period_val = CfgDataBits'($urandom_range(32'h1000_0000));
    end else if (kind == 1) begin
      start_val  = (phase % 2 == 0) ? '1 : '0;
      period_val = (phase % 2 == 0) ? '1 : '0;
    end
    for (j = 0; j < SlotCount; j++) begin
      data = (kind == 2) ? {$urandom, $urandom} : '0;
      data[ChanBits-1:0] = pool[j];
      write_reg(CfgIdxBits'(j), data);
    end
    write_reg(RegStartTime, start_val);
    write_reg(RegPeriod, period_val);
    write_reg(CfgIdxBits'($urandom_range((1 << CfgIdxBits) - 1, int'(RegPeriod) + 1)),
              {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  // one scan in random slot order, with noise, repeats and early aborts
  task automatic send_scan();
    int order [SlotCount];
    int j;
    int k;
    int tmp;
    for (j = 0; j < SlotCount; j++) order[j] = j;
    for (j = SlotCount - 1; j > 0; j--) begin
      k = $urandom_range(j);
      tmp = order[j];
      order[j] = order[k];
      order[k] = tmp;
    end
    for (j = 0; j < SlotCount; j++) begin
      if ($urandom_range(99) < 3) break;
      if ($urandom_range(99) < 8) begin
        send_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                  ChanBits'($urandom_range(15)), SampleBits'($urandom_range(4095)));
      end
      if (j > 0 && $urandom_range(99) < 4) begin
        send_item(1'b1, 1'b0, scan_chan[order[$urandom_range(j - 1)]],
                  SampleBits'($urandom_range(4095)));
      end
      send_item(1'b1, 1'b0, scan_chan[order[j]], SampleBits'($urandom_range(4095)));
    end
  endtask

  initial begin
    int s;
    int phase;
    int seg;
    int target;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    sample_valid  = 1'b0;
    adc_unit      = 1'b0;
    channel       = '0;
    raw_sample    = '0;
    out_stall     = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    items_sent    = 0;
    idle_cycles   = 0;
    for (s = 0; s < SlotCount; s++) scan_chan[s] = ChanBits'(s);
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // rejects and an unmatched channel
    send_item(1'b0, 1'b0, 4'd0, '1);
    send_item(1'b1, 1'b1, 4'd0, '0);
    send_item(1'b0, 1'b1, 4'd15, '1);
    send_item(1'b1, 1'b0, 4'd15, '0);
    // full frame in slot order, sample extremes
    for (s = 0; s < SlotCount; s++) send_item(1'b1, 1'b0, ChanBits'(s), s[0] ? '1 : '0);
    // repeated slot abandons the scan, then finish it
    send_item(1'b1, 1'b0, 4'd0, 12'h5a5);
    send_item(1'b1, 1'b0, 4'd1, 12'h3c3);
    send_item(1'b1, 1'b0, 4'd0, 12'ha5a);
    for (s = 1; s < SlotCount; s++) begin
      send_item(1'b1, 1'b0, ChanBits'(s), SampleBits'($urandom_range(4095)));
    end
    // reverse order frame
    for (s = SlotCount - 1; s >= 0; s--) begin
      send_item(1'b1, 1'b0, ChanBits'(s), s[0] ? '0 : '1);
    end

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 66 : 0;
      recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 31 : 0;
      for (seg = 0; seg < 3; seg++) begin
        configure(seg, phase);
        target = items_sent + SegItems;
        while (items_sent < target) send_scan();
      end
    end

    in_valid <= 1'b0;
    while (pending_beats != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (fail_count == 0 && pending_beats == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
